// File: src/btsa_pkg.sv
// Shared constants and types of the boundary-tag stack allocator.
`timescale 1ns / 1ps

package btsa_pkg;

  localparam int HEAP_WORDS  = 16384;
  localparam int WORD_BYTES  = 4;
  localparam int ALIGN_BYTES = 8;
  localparam int HEAP_BASE   = 0;
  localparam int USED_TAG    = 1;
  localparam int FREE_TAG    = 2;

  localparam int WORD_W   = WORD_BYTES * 8;
  localparam int HEAP_END = HEAP_BASE + HEAP_WORDS * WORD_BYTES;
  localparam int IDX_W    = $clog2(HEAP_WORDS);
  localparam int WB_SHIFT = $clog2(WORD_BYTES);

  // Both alignments are powers of two, so rounding to the larger one covers both.
  localparam int ROUND_BYTES = (ALIGN_BYTES > WORD_BYTES) ? ALIGN_BYTES : WORD_BYTES;

  localparam int ACTION_W = 3;
  localparam int SIZE_W   = 17;
  localparam int ADDR_W   = 17;
  localparam int NSZ_W    = 18;
  localparam int RES_W    = 16;
  localparam int STATUS_W = 2;
  localparam int ALU_W    = WORD_W + 2;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC    = 3'd0,
    ACT_FREE     = 3'd1,
    ACT_RELEASE  = 3'd2,
    ACT_SET_MARK = 3'd3,
    ACT_REWIND   = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_DECODE  = 15'b000000000000010,
    S_AL_FIT  = 15'b000000000000100,
    S_AL_FLAG = 15'b000000000001000,
    S_AL_END  = 15'b000000000010000,
    S_AL_TAIL = 15'b000000000100000,
    S_FR_FLAG = 15'b000000001000000,
    S_FR_SIZE = 15'b000000010000000,
    S_FR_MARK = 15'b000000100000000,
    S_FR_PULL = 15'b000001000000000,
    S_WK_TEST = 15'b000010000000000,
    S_WK_SIZE = 15'b000100000000000,
    S_WK_FLAG = 15'b001000000000000,
    S_RESULT  = 15'b010000000000000,
    S_SPARE   = 15'b100000000000000
  } state_t;

endpackage

// File: src/btsa_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module btsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: src/boundary_tag_stack_allocator.sv
// Boundary-tag stack allocator: a bump allocator with tagged blocks over a word RAM.
//
// Input channel s_axis carries one request item: an action code (alloc, free,
// release to mark, set mark, rewind), an allocation size in bytes and a block
// address. Output channel m_axis returns exactly one result item per request:
// the payload address of a new block, the tail pointer after the action and
// a status code (done, out of memory, ignored).
// All work runs through one three-operand adder under a small sequencer and a
// single-port heap RAM with registered reads, one request at a time.
// Mark, release, rewind and unknown codes finish in the decode step; an alloc
// checks the fit, then writes the head tag, used flag and end tag. A free is
// refused at the decode, flag or size check. A free that leaves the block inside
// the heap only marks it free; one that pulls the tail back also walks backward,
// absorbing each earlier free block, until the walk stops.
// The next request is taken once the sequencer is back in idle, even while the
// previous result still waits in the output register; a stalled receiver holds
// the block only when a new result is ready to be loaded.
// Reset sets tail and mark to the heap base and empties the output register.
// Heap words come up undefined; no clearing pass runs after reset.
`timescale 1ns / 1ps

module boundary_tag_stack_allocator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // action [2:0], alloc_size [19:3], block_address [36:20], zero [39:37]
  input  logic [btsa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // result_address [15:0], current_tail [32:16], status [34:33], zero [39:35]
  output logic [btsa_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  btsa_pkg::state_t state, state_next;

  logic [btsa_pkg::ACTION_W-1:0] act, act_next;
  logic [btsa_pkg::SIZE_W-1:0]   size_in, size_in_next;
  logic [btsa_pkg::ADDR_W-1:0]   addr_in, addr_in_next;
  logic [btsa_pkg::NSZ_W-1:0]    nsz, nsz_next;
  logic [btsa_pkg::ADDR_W-1:0]   tail, tail_next;
  logic [btsa_pkg::ADDR_W-1:0]   mark, mark_next;
  logic [btsa_pkg::ADDR_W-1:0]   ptr, ptr_next;
  logic [btsa_pkg::ADDR_W-1:0]   probe, probe_next;
  logic [btsa_pkg::RES_W-1:0]    result, result_next;
  btsa_pkg::status_t             status, status_next;
  logic                          at_tail, at_tail_next;

  logic                          out_valid;
  logic [btsa_pkg::RES_W-1:0]    out_result;
  logic [btsa_pkg::ADDR_W-1:0]   out_tail;
  btsa_pkg::status_t             out_status;
  logic                          out_load;

  logic [btsa_pkg::ALU_W-1:0]    alu_a, alu_b, alu_c, alu_sum;

  logic                          ram_we;
  logic [btsa_pkg::IDX_W-1:0]    ram_addr;
  logic [btsa_pkg::WORD_W-1:0]   ram_wdata, ram_rdata;

  logic                          free_bad;
  logic                          rewind_ok;

  btsa_ram #(
    .WIDTH(btsa_pkg::WORD_W),
    .DEPTH(btsa_pkg::HEAP_WORDS)
  ) u_heap (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // Shared adder: operand selection per sequencer step.
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    alu_c = '0;
    unique case (state)
      btsa_pkg::S_DECODE: begin
        if (act == btsa_pkg::ACT_ALLOC) begin
          alu_a = btsa_pkg::ALU_W'(size_in);
          alu_c = btsa_pkg::ALU_W'(btsa_pkg::ROUND_BYTES - 1);
        end else begin
          alu_a = btsa_pkg::ALU_W'(addr_in);
          alu_c = -btsa_pkg::ALU_W'(btsa_pkg::WORD_BYTES);
        end
      end
      btsa_pkg::S_AL_FIT: begin
        alu_a = btsa_pkg::ALU_W'(tail);
        alu_b = btsa_pkg::ALU_W'(nsz);
        alu_c = btsa_pkg::ALU_W'(3 * btsa_pkg::WORD_BYTES);
      end
      btsa_pkg::S_AL_FLAG: begin
        alu_a = btsa_pkg::ALU_W'(tail);
        alu_c = btsa_pkg::ALU_W'(btsa_pkg::WORD_BYTES);
      end
      btsa_pkg::S_AL_END: begin
        alu_a = btsa_pkg::ALU_W'(ptr);
        alu_c = -btsa_pkg::ALU_W'(btsa_pkg::WORD_BYTES);
      end
      btsa_pkg::S_AL_TAIL: begin
        alu_a = btsa_pkg::ALU_W'(tail);
        alu_c = btsa_pkg::ALU_W'(2 * btsa_pkg::WORD_BYTES);
      end
      btsa_pkg::S_FR_FLAG, btsa_pkg::S_FR_PULL: begin
        alu_a = btsa_pkg::ALU_W'(addr_in);
        alu_c = -btsa_pkg::ALU_W'(2 * btsa_pkg::WORD_BYTES);
      end
      btsa_pkg::S_FR_SIZE: begin
        alu_a = btsa_pkg::ALU_W'(addr_in);
        alu_b = btsa_pkg::ALU_W'(ram_rdata);
        alu_c = btsa_pkg::ALU_W'(btsa_pkg::WORD_BYTES);
      end
      btsa_pkg::S_FR_MARK: begin
        alu_a = btsa_pkg::ALU_W'(addr_in);
        alu_c = -btsa_pkg::ALU_W'(btsa_pkg::WORD_BYTES);
      end
      btsa_pkg::S_WK_TEST: begin
        alu_a = btsa_pkg::ALU_W'(ptr);
        alu_c = -btsa_pkg::ALU_W'(btsa_pkg::WORD_BYTES);
      end
      btsa_pkg::S_WK_SIZE: begin
        // Start of the previous block's flag word: r - 2 words - its size.
        alu_a = btsa_pkg::ALU_W'(ptr);
        alu_b = -btsa_pkg::ALU_W'(ram_rdata);
        alu_c = -btsa_pkg::ALU_W'(2 * btsa_pkg::WORD_BYTES);
      end
      btsa_pkg::S_WK_FLAG: begin
        alu_a = btsa_pkg::ALU_W'(probe);
        alu_c = -btsa_pkg::ALU_W'(btsa_pkg::WORD_BYTES);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_sum = alu_a + alu_b + alu_c;

  // The head tag of a new block goes to the old tail while the adder checks the fit.
  assign ram_addr = (state == btsa_pkg::S_AL_FIT) ?
                    tail[btsa_pkg::WB_SHIFT +: btsa_pkg::IDX_W] :
                    alu_sum[btsa_pkg::WB_SHIFT +: btsa_pkg::IDX_W];

  assign free_bad = (addr_in < btsa_pkg::ADDR_W'(2 * btsa_pkg::WORD_BYTES)) ||
                    (addr_in >= btsa_pkg::ADDR_W'(btsa_pkg::HEAP_END)) ||
                    (addr_in[btsa_pkg::WB_SHIFT-1:0] != '0) ||
                    (addr_in >= tail);

  assign rewind_ok = (addr_in[btsa_pkg::WB_SHIFT-1:0] == '0) &&
                     (addr_in <= btsa_pkg::ADDR_W'(btsa_pkg::HEAP_END));

  assign out_load = (state == btsa_pkg::S_RESULT) && (!out_valid || m_axis_tready);

  always_comb begin
    state_next   = state;
    act_next     = act;
    size_in_next = size_in;
    addr_in_next = addr_in;
    nsz_next     = nsz;
    tail_next    = tail;
    mark_next    = mark;
    ptr_next     = ptr;
    probe_next   = probe;
    result_next  = result;
    status_next  = status;
    at_tail_next = at_tail;
    ram_we       = 1'b0;
    ram_wdata    = '0;
    unique case (state)
      btsa_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          act_next     = s_axis_tdata[2:0];
          size_in_next = s_axis_tdata[19:3];
          addr_in_next = s_axis_tdata[36:20];
          result_next  = '0;
          status_next  = btsa_pkg::ST_DONE;
          state_next   = btsa_pkg::S_DECODE;
        end
      end
      btsa_pkg::S_DECODE: begin
        state_next = btsa_pkg::S_RESULT;
        case (act)
          btsa_pkg::ACT_ALLOC: begin
            nsz_next   = alu_sum[btsa_pkg::NSZ_W-1:0] &
                         ~btsa_pkg::NSZ_W'(btsa_pkg::ROUND_BYTES - 1);
            state_next = btsa_pkg::S_AL_FIT;
          end
          btsa_pkg::ACT_FREE: begin
            if (free_bad) begin
              status_next = btsa_pkg::ST_IGNORED;
            end else begin
              state_next = btsa_pkg::S_FR_FLAG;
            end
          end
          btsa_pkg::ACT_RELEASE: begin
            tail_next = mark;
          end
          btsa_pkg::ACT_SET_MARK: begin
            mark_next = tail;
          end
          btsa_pkg::ACT_REWIND: begin
            if (rewind_ok) begin
              tail_next = addr_in;
            end else begin
              status_next = btsa_pkg::ST_IGNORED;
            end
          end
          default: begin
            status_next = btsa_pkg::ST_IGNORED;
          end
        endcase
      end
      btsa_pkg::S_AL_FIT: begin
        if (alu_sum > btsa_pkg::ALU_W'(btsa_pkg::HEAP_END)) begin
          status_next = btsa_pkg::ST_NOMEM;
          state_next  = btsa_pkg::S_RESULT;
        end else begin
          ram_we     = 1'b1;
          ram_wdata  = btsa_pkg::WORD_W'(nsz);
          ptr_next   = alu_sum[btsa_pkg::ADDR_W-1:0];
          state_next = btsa_pkg::S_AL_FLAG;
        end
      end
      btsa_pkg::S_AL_FLAG: begin
        ram_we     = 1'b1;
        ram_wdata  = btsa_pkg::WORD_W'(btsa_pkg::USED_TAG);
        state_next = btsa_pkg::S_AL_END;
      end
      btsa_pkg::S_AL_END: begin
        ram_we     = 1'b1;
        ram_wdata  = btsa_pkg::WORD_W'(nsz);
        state_next = btsa_pkg::S_AL_TAIL;
      end
      btsa_pkg::S_AL_TAIL: begin
        result_next = alu_sum[btsa_pkg::RES_W-1:0];
        tail_next   = ptr;
        state_next  = btsa_pkg::S_RESULT;
      end
      btsa_pkg::S_FR_FLAG: begin
        if (ram_rdata != btsa_pkg::WORD_W'(btsa_pkg::USED_TAG)) begin
          status_next = btsa_pkg::ST_IGNORED;
          state_next  = btsa_pkg::S_RESULT;
        end else begin
          state_next = btsa_pkg::S_FR_SIZE;
        end
      end
      btsa_pkg::S_FR_SIZE: begin
        // The block must end at or below the tail.
        if (alu_sum > btsa_pkg::ALU_W'(tail)) begin
          status_next = btsa_pkg::ST_IGNORED;
          state_next  = btsa_pkg::S_RESULT;
        end else begin
          at_tail_next = (alu_sum == btsa_pkg::ALU_W'(tail));
          state_next   = btsa_pkg::S_FR_MARK;
        end
      end
      btsa_pkg::S_FR_MARK: begin
        ram_we     = 1'b1;
        ram_wdata  = btsa_pkg::WORD_W'(btsa_pkg::FREE_TAG);
        state_next = at_tail ? btsa_pkg::S_FR_PULL : btsa_pkg::S_RESULT;
      end
      btsa_pkg::S_FR_PULL: begin
        tail_next  = alu_sum[btsa_pkg::ADDR_W-1:0];
        ptr_next   = alu_sum[btsa_pkg::ADDR_W-1:0];
        state_next = btsa_pkg::S_WK_TEST;
      end
      btsa_pkg::S_WK_TEST: begin
        if (ptr < btsa_pkg::ADDR_W'(3 * btsa_pkg::WORD_BYTES)) begin
          state_next = btsa_pkg::S_RESULT;
        end else begin
          state_next = btsa_pkg::S_WK_SIZE;
        end
      end
      btsa_pkg::S_WK_SIZE: begin
        // A misaligned size, or one that would reach below the heap, ends the walk.
        if ((ram_rdata[btsa_pkg::WB_SHIFT-1:0] != '0) || alu_sum[btsa_pkg::ALU_W-1] ||
            (alu_sum < btsa_pkg::ALU_W'(btsa_pkg::WORD_BYTES))) begin
          state_next = btsa_pkg::S_RESULT;
        end else begin
          probe_next = alu_sum[btsa_pkg::ADDR_W-1:0];
          state_next = btsa_pkg::S_WK_FLAG;
        end
      end
      btsa_pkg::S_WK_FLAG: begin
        if (ram_rdata != btsa_pkg::WORD_W'(btsa_pkg::FREE_TAG)) begin
          state_next = btsa_pkg::S_RESULT;
        end else begin
          tail_next  = alu_sum[btsa_pkg::ADDR_W-1:0];
          ptr_next   = alu_sum[btsa_pkg::ADDR_W-1:0];
          state_next = btsa_pkg::S_WK_TEST;
        end
      end
      btsa_pkg::S_RESULT: begin
        if (out_load) begin
          state_next = btsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = btsa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= btsa_pkg::S_IDLE;
      tail      <= btsa_pkg::ADDR_W'(btsa_pkg::HEAP_BASE);
      mark      <= btsa_pkg::ADDR_W'(btsa_pkg::HEAP_BASE);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      tail  <= tail_next;
      mark  <= mark_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    act     <= act_next;
    size_in <= size_in_next;
    addr_in <= addr_in_next;
    nsz     <= nsz_next;
    ptr     <= ptr_next;
    probe   <= probe_next;
    result  <= result_next;
    status  <= status_next;
    at_tail <= at_tail_next;
    if (out_load) begin
      out_result <= result;
      out_tail   <= tail;
      out_status <= status;
    end
  end

  assign s_axis_tready = (state == btsa_pkg::S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_status, out_tail, out_result};

`ifndef ASSERT_OFF
  a_tail_aligned: assert property (@(posedge clk) disable iff (rst)
    tail[btsa_pkg::WB_SHIFT-1:0] == '0)
    else $error("tail pointer lost word alignment");

  a_tail_in_heap: assert property (@(posedge clk) disable iff (rst)
    tail <= btsa_pkg::ADDR_W'(btsa_pkg::HEAP_END))
    else $error("tail pointer beyond heap end");

  a_nomem_no_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status == btsa_pkg::ST_NOMEM)) |-> (out_result == '0))
    else $error("failed alloc reports a block address");

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == btsa_pkg::S_DECODE))
    else $error("accepted item not decoded");
`endif

endmodule
